@@ rtl/aarch64_instruction_classifier_core_defines.svh @@
// Assertion macros for the instruction classifier.
`ifndef AARCH64_INSTRUCTION_CLASSIFIER_CORE_DEFINES_SVH
`define AARCH64_INSTRUCTION_CLASSIFIER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define AIC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define AIC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/aic_pkg.sv @@
// Package: operation codes, field types and the decode result structure.
`timescale 1ns / 1ps
package aic_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [6:0] {
    K_NONE, K_BL, K_B, K_BCOND, K_CBNZ, K_CBZ, K_TBNZ, K_TBZ, K_BR, K_BLR,
    K_RET, K_RETAA, K_PACIASP, K_AUTIASP, K_CMP, K_CMN, K_SUBS, K_ADDS,
    K_SUB, K_ADD, K_MOVREG, K_MVN, K_TST, K_BIC, K_AND, K_ORN, K_ORR,
    K_EON, K_EOR, K_ANDS, K_MOVK, K_MOVIMM, K_ADRP, K_ADR, K_CSEL,
    K_CSINC, K_CSINV, K_CSNEG, K_CCMP, K_CCMN, K_MUL, K_MSUB, K_MADD,
    K_SMULL, K_UMULL, K_SMULH, K_UMULH, K_UDIV, K_SDIV, K_LSL, K_LSR,
    K_ASR, K_ROR, K_SBFM, K_BFM, K_UBFM, K_EXTR, K_STRB, K_STRH, K_STR,
    K_LDRB, K_LDRH, K_LDR, K_NOP, K_LDRSB, K_LDRSH, K_LDRSW, K_LDP,
    K_STP, K_LDXR, K_STXR, K_DMB, K_DSB, K_ISB, K_BRK, K_SVC, K_MRS,
    K_MSR, K_SIMD
  } op_kind_t;

  typedef enum logic [2:0] {
    M_NONE, M_OFF, M_POST, M_PRE, M_REG, M_LIT
  } mem_mode_t;

  localparam logic [5:0] F_64  = 6'd1;
  localparam logic [5:0] F_SET = 6'd2;
  localparam logic [5:0] F_RDF = 6'd4;
  localparam logic [5:0] F_CF  = 6'd8;
  localparam logic [5:0] F_PRV = 6'd16;
  localparam logic [5:0] F_SP  = 6'd32;

  typedef struct packed {
    logic        is_valid;
    logic [6:0]  op_kind;
    logic [63:0] immediate;
    logic [27:0] branch_offset;
    logic [3:0]  condition;
    logic [19:0] reg_fields;
    logic [5:0]  attr_flags;
    logic [7:0]  shift_info;
    logic [5:0]  test_bit;
    logic [5:0]  mem_access;
    logic [22:0] reads_list;
    logic [11:0] writes_list;
  } dec_res_t;

endpackage

@@ rtl/aic_if.sv @@
// Valid/ready channel interfaces for instruction words and decode results.
`timescale 1ns / 1ps
interface aic_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

interface aic_out_if;
  import aic_pkg::*;
  logic     valid;
  logic     ready;
  dec_res_t res;
  modport source (output valid, output res, input ready);
  modport sink   (input valid, input res, output ready);
endinterface

@@ rtl/aic_bitmask.sv @@
// Logical-immediate bitmask expansion.
`timescale 1ns / 1ps
module aic_bitmask
  import aic_pkg::*;
(
  input  logic        sf,
  input  logic        n,
  input  logic [5:0]  immr,
  input  logic [5:0]  imms,
  output logic [63:0] mask
);
  logic [6:0]  comb;
  logic [2:0]  len;
  logic [5:0]  emsk;
  logic [5:0]  s;
  logic [5:0]  r;
  logic [63:0] el;
  logic [63:0] rot;
  logic [63:0] rep;

  always_comb begin
    comb = {n, ~imms};
    len = 3'd0;
    for (int i = 1; i <= 6; i++) begin
      if (comb[i]) len = 3'(i);
    end
    emsk = 6'((7'd1 << len) - 7'd1);
    s = imms & emsk;
    r = immr & emsk;
    el = (64'd2 << s) - 64'd1;
    if (s == 6'd63) el = '1;
    // rotate right by r within element: the index wraps within the element
    rot = '0;
    for (int k = 0; k < 64; k++) begin
      if (6'(k) <= emsk) rot[k] = el[(6'(k) + r) & emsk];
    end
    rep = '0;
    for (int k = 0; k < 64; k++) rep[k] = rot[6'(k) & emsk];
    mask = (len == 3'd0) ? 64'd0 : rep;
    if (!sf) mask[63:32] = '0;
  end
endmodule

@@ rtl/aic_decode.sv @@
// Combinational instruction decode in priority order.
`timescale 1ns / 1ps
module aic_decode
  import aic_pkg::*;
(
  input  logic [31:0] w,
  output dec_res_t    res
);
  logic [4:0]  rd, rn, rm, ra;
  logic        sf, b30, b29;
  logic [63:0] bmask;
  op_kind_t    kind;
  logic [63:0] imm;
  logic [27:0] tgt;
  logic [3:0]  cond;
  logic [5:0]  flags;
  logic [1:0]  sht;
  logic [5:0]  sha;
  logic [5:0]  tbit;
  mem_mode_t   mode;
  logic [2:0]  size;
  logic [4:0]  rl [4];
  logic [2:0]  nr;
  logic [4:0]  wl [2];
  logic [1:0]  nw;
  logic        ok;
  logic [1:0]  opc, sz, idx;
  logic [2:0]  op31;
  logic [15:0] i16;
  logic [5:0]  sh;
  logic [63:0] v21;
  logic [63:0] m16;

  assign rd = w[4:0];
  assign rn = w[9:5];
  assign rm = w[20:16];
  assign ra = w[14:10];
  assign sf = w[31];
  assign b30 = w[30];
  assign b29 = w[29];

  aic_bitmask u_bm (
    .sf(sf), .n(w[22]), .immr(w[21:16]), .imms(w[15:10]), .mask(bmask)
  );

  always_comb begin
    kind = K_NONE; imm = '0; tgt = '0; cond = '0; flags = '0; sht = '0; sha = '0;
    tbit = '0; mode = M_NONE; size = '0; nr = '0; nw = '0; ok = 1'b1;
    rl = '{default: '0}; wl = '{default: '0};
    opc = w[30:29]; sz = w[31:30]; idx = w[24:23]; op31 = w[23:21];
    i16 = w[20:5]; sh = {w[22:21], 4'd0};
    v21 = {{43{w[23]}}, w[23:5], w[30:29]};
    m16 = 64'(i16) << sh;

    if ((w & 32'h7C000000) == 32'h14000000) begin
      kind = sf ? K_BL : K_B;
      imm = {{36{w[25]}}, w[25:0], 2'b00}; tgt = {w[25:0], 2'b00}; flags = F_CF;
      if (sf) begin wl[0] = 5'd30; nw = 2'd1; end
    end else if ((w & 32'hFF000010) == 32'h54000000) begin
      kind = K_BCOND; tgt = 28'({{9{w[23]}}, w[23:5], 2'b00});
      cond = w[3:0]; flags = F_RDF | F_CF;
    end else if ((w & 32'h7E000000) == 32'h34000000) begin
      kind = w[24] ? K_CBNZ : K_CBZ; tgt = 28'({{9{w[23]}}, w[23:5], 2'b00});
      flags = F_CF | (sf ? F_64 : 6'd0);
      if (rd != 5'd31) begin rl[0] = rd; nr = 3'd1; end
    end else if ((w & 32'h7E000000) == 32'h36000000) begin
      kind = w[24] ? K_TBNZ : K_TBZ; tgt = 28'({{14{w[18]}}, w[18:5], 2'b00});
      tbit = {sf, w[23:19]}; flags = F_CF | (sf ? F_64 : 6'd0);
      if (rd != 5'd31) begin rl[0] = rd; nr = 3'd1; end
    end else if ((w & 32'hFFFFFC1F) == 32'hD61F0000) begin
      kind = K_BR; flags = F_CF;
      if (rn != 5'd31) begin rl[0] = rn; nr = 3'd1; end
    end else if ((w & 32'hFFFFFC1F) == 32'hD63F0000) begin
      kind = K_BLR; flags = F_CF; wl[0] = 5'd30; nw = 2'd1;
      if (rn != 5'd31) begin rl[0] = rn; nr = 3'd1; end
    end else if ((w & 32'hFFFFFC1F) == 32'hD65F0000) begin
      kind = K_RET; flags = F_CF;
      if (rn != 5'd31) begin rl[0] = rn; nr = 3'd1; end
    end else if ((w & 32'hFFFFFBFF) == 32'hD65F0BFF) begin
      kind = K_RETAA; flags = F_CF;
    end else if ((w & 32'hFFFFFBFF) == 32'hD503233F) begin
      kind = K_PACIASP; flags = F_PRV;
    end else if ((w & 32'hFFFFFBFF) == 32'hD50323BF) begin
      kind = K_AUTIASP; flags = F_PRV;
    end else if ((w & 32'hFFFFFC00) == 32'hDAC10000) begin
      kind = K_PACIASP; flags = F_PRV;
    end else if ((w & 32'hFFFFFC00) == 32'hDAC11000) begin
      kind = K_AUTIASP; flags = F_PRV;
    end else if ((w & 32'h1F000000) == 32'h11000000 ||
                 (w & 32'h1F000000) == 32'h0B000000) begin
      flags = (sf ? F_64 : 6'd0) | (b29 ? F_SET : 6'd0);
      if (w[27]) begin
        sht = w[23:22]; sha = w[15:10];
      end else begin
        imm = w[22] ? {40'd0, w[21:10], 12'd0} : {52'd0, w[21:10]};
        flags = flags | F_SP;
      end
      if (rn != 5'd31) begin rl[nr[1:0]] = rn; nr = nr + 3'd1; end
      if (w[27] && rm != 5'd31) begin rl[nr[1:0]] = rm; nr = nr + 3'd1; end
      if (b29 && rd == 5'd31) kind = b30 ? K_CMP : K_CMN;
      else begin
        kind = b29 ? (b30 ? K_SUBS : K_ADDS) : (b30 ? K_SUB : K_ADD);
        if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
      end
    end else if ((w & 32'h1F000000) == 32'h0A000000) begin
      sht = w[23:22]; sha = w[15:10]; flags = sf ? F_64 : 6'd0;
      if (opc == 2'd1 && !w[21] && rn == 5'd31 && sht == 2'd0 && sha == 6'd0) begin
        kind = K_MOVREG;
        if (rm != 5'd31) begin rl[0] = rm; nr = 3'd1; end
        if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
      end else if (opc == 2'd1 && w[21] && rn == 5'd31) begin
        kind = K_MVN;
        if (rm != 5'd31) begin rl[0] = rm; nr = 3'd1; end
        if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
      end else begin
        if (opc == 2'd3 && rd == 5'd31) begin
          kind = K_TST; flags = flags | F_SET;
        end else begin
          case (opc)
            2'd0: kind = w[21] ? K_BIC : K_AND;
            2'd1: kind = w[21] ? K_ORN : K_ORR;
            2'd2: kind = w[21] ? K_EON : K_EOR;
            default: begin kind = K_ANDS; flags = flags | F_SET; end
          endcase
          if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
        end
        if (rn != 5'd31) begin rl[nr[1:0]] = rn; nr = nr + 3'd1; end
        if (rm != 5'd31) begin rl[nr[1:0]] = rm; nr = nr + 3'd1; end
      end
    end else if ((w & 32'h1F800000) == 32'h12000000) begin
      imm = bmask; flags = sf ? F_64 : 6'd0;
      if (rn != 5'd31) begin rl[0] = rn; nr = 3'd1; end
      if (opc == 2'd3 && rd == 5'd31) begin
        kind = K_TST; flags = flags | F_SET;
      end else begin
        case (opc)
          2'd0: kind = K_AND;
          2'd1: kind = K_ORR;
          2'd2: kind = K_EOR;
          default: begin kind = K_ANDS; flags = flags | F_SET; end
        endcase
        if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
      end
    end else if ((w & 32'h1F800000) == 32'h12800000) begin
      flags = sf ? F_64 : 6'd0;
      if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
      if (opc == 2'd3) begin
        kind = K_MOVK; imm = 64'(i16); sha = sh;
        if (rd != 5'd31) begin rl[0] = rd; nr = 3'd1; end
      end else begin
        kind = K_MOVIMM;
        if (opc == 2'd2) imm = m16;
        else imm = ~m16 & (sf ? 64'hFFFFFFFF_FFFFFFFF : 64'h00000000_FFFFFFFF);
      end
    end else if ((w & 32'h1F000000) == 32'h10000000) begin
      kind = sf ? K_ADRP : K_ADR;
      imm = sf ? (v21 << 12) : v21;
      flags = F_64 | F_CF;
      if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
    end else if ((w & 32'h1FE00000) == 32'h1A800000) begin
      cond = w[15:12]; flags = (sf ? F_64 : 6'd0) | F_RDF;
      if (!b30 && w[11:10] == 2'd0) kind = K_CSEL;
      else if (!b30 && w[11:10] == 2'd1) kind = K_CSINC;
      else if (b30 && w[11:10] == 2'd0) kind = K_CSINV;
      else kind = K_CSNEG;
      if (rn != 5'd31) begin rl[nr[1:0]] = rn; nr = nr + 3'd1; end
      if (rm != 5'd31) begin rl[nr[1:0]] = rm; nr = nr + 3'd1; end
      if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
    end else if ((w & 32'h1FE00000) == 32'h1A400000) begin
      kind = b30 ? K_CCMP : K_CCMN; cond = w[15:12]; imm = 64'(w[3:0]);
      flags = (sf ? F_64 : 6'd0) | F_SET | F_RDF;
      if (rn != 5'd31) begin rl[nr[1:0]] = rn; nr = nr + 3'd1; end
      if (!w[11] && rm != 5'd31) begin rl[nr[1:0]] = rm; nr = nr + 3'd1; end
    end else if ((w & 32'h1F000000) == 32'h1B000000) begin
      flags = sf ? F_64 : 6'd0;
      case (op31)
        3'd0: kind = (ra == 5'd31) ? K_MUL : (w[15] ? K_MSUB : K_MADD);
        3'd1: kind = w[15] ? K_MSUB : K_SMULL;
        3'd5: kind = w[15] ? K_MSUB : K_UMULL;
        3'd2: kind = K_SMULH;
        3'd6: kind = K_UMULH;
        default: kind = K_MUL;
      endcase
      if (rn != 5'd31) begin rl[nr[1:0]] = rn; nr = nr + 3'd1; end
      if (rm != 5'd31) begin rl[nr[1:0]] = rm; nr = nr + 3'd1; end
      if (ra != 5'd31 && kind != K_MUL) begin rl[nr[1:0]] = ra; nr = nr + 3'd1; end
      if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
    end else if ((w & 32'h1FE00000) == 32'h1AC00000) begin
      case (w[15:10])
        6'h02: kind = K_UDIV;
        6'h03: kind = K_SDIV;
        6'h08: kind = K_LSL;
        6'h09: kind = K_LSR;
        6'h0A: kind = K_ASR;
        6'h0B: kind = K_ROR;
        default: ok = 1'b0;
      endcase
      flags = sf ? F_64 : 6'd0;
      if (rn != 5'd31) begin rl[nr[1:0]] = rn; nr = nr + 3'd1; end
      if (rm != 5'd31) begin rl[nr[1:0]] = rm; nr = nr + 3'd1; end
      if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
    end else if ((w & 32'h1F800000) == 32'h13000000) begin
      flags = sf ? F_64 : 6'd0; imm = 64'(w[21:16]); sha = w[15:10];
      kind = (opc == 2'd0) ? K_SBFM : (opc == 2'd2) ? K_UBFM : K_BFM;
      if (rn != 5'd31) begin rl[nr[1:0]] = rn; nr = nr + 3'd1; end
      if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
      if (opc == 2'd1 && rd != 5'd31) begin rl[nr[1:0]] = rd; nr = nr + 3'd1; end
    end else if ((w & 32'h1F800000) == 32'h13800000) begin
      kind = (rn == rm) ? K_ROR : K_EXTR; flags = sf ? F_64 : 6'd0;
      imm = 64'(w[15:10]);
      if (rn != 5'd31) begin rl[nr[1:0]] = rn; nr = nr + 3'd1; end
      if (rm != 5'd31) begin rl[nr[1:0]] = rm; nr = nr + 3'd1; end
      if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
    end else if ((w & 32'h3B000000) == 32'h39000000) begin
      imm = 64'(w[21:10]) << sz;
      flags = ((sz == 2'd3) ? F_64 : 6'd0) | F_SP;
      size = 3'(sz) + 3'd1; mode = M_OFF;
      if (w[23:22] == 2'd0) begin
        kind = (sz == 2'd0) ? K_STRB : (sz == 2'd1) ? K_STRH : K_STR;
        if (rd != 5'd31) begin rl[nr[1:0]] = rd; nr = nr + 3'd1; end
      end else if (w[23:22] == 2'd1) begin
        kind = (sz == 2'd0) ? K_LDRB : (sz == 2'd1) ? K_LDRH : K_LDR;
        if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
      end else if (sz == 2'd3) begin
        kind = K_NOP;
      end else begin
        kind = (sz == 2'd0) ? K_LDRSB : (sz == 2'd1) ? K_LDRSH : K_LDRSW;
        if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
      end
      if (kind != K_NOP && rn != 5'd31) begin rl[nr[1:0]] = rn; nr = nr + 3'd1; end
    end else if ((w & 32'h3E000000) == 32'h28000000) begin
      imm = (sz == 2'd0) ? {{55{w[21]}}, w[21:15], 2'd0} : {{54{w[21]}}, w[21:15], 3'd0};
      flags = ((sz == 2'd2) ? F_64 : 6'd0) | F_SP;
      size = (sz == 2'd0) ? 3'd3 : 3'd4;
      kind = w[22] ? K_LDP : K_STP;
      mode = (idx == 2'd1) ? M_POST : (idx == 2'd2) ? M_OFF : M_PRE;
      if (w[22]) begin
        if (rd != 5'd31) begin wl[nw[0]] = rd; nw = nw + 2'd1; end
        if (ra != 5'd31) begin wl[nw[0]] = ra; nw = nw + 2'd1; end
      end else begin
        if (rd != 5'd31) begin rl[nr[1:0]] = rd; nr = nr + 3'd1; end
        if (ra != 5'd31) begin rl[nr[1:0]] = ra; nr = nr + 3'd1; end
      end
      if (rn != 5'd31) begin rl[nr[1:0]] = rn; nr = nr + 3'd1; end
      if (mode != M_OFF && rn != 5'd31 && nw != 2'd2) begin
        wl[nw[0]] = rn; nw = nw + 2'd1;
      end
    end else if ((w & 32'h3B000000) == 32'h18000000) begin
      kind = K_LDR; tgt = 28'({{9{w[23]}}, w[23:5], 2'b00});
      imm = {{43{w[23]}}, w[23:5], 2'b00};
      flags = b30 ? F_64 : 6'd0; size = b30 ? 3'd4 : 3'd3; mode = M_LIT;
      if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
    end else if ((w & 32'h3B000000) == 32'h38000000) begin
      flags = ((sz == 2'd3) ? F_64 : 6'd0) | F_SP; size = 3'(sz) + 3'd1;
      if (w[21]) begin
        mode = M_REG;
        if (rm != 5'd31) begin rl[nr[1:0]] = rm; nr = nr + 3'd1; end
      end else begin
        imm = {{55{w[20]}}, w[20:12]};
        mode = (w[11:10] == 2'd0) ? M_OFF : (w[11:10] == 2'd1) ? M_POST : M_PRE;
      end
      if (w[22]) begin
        kind = K_LDR;
        if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
      end else begin
        kind = K_STR;
        if (rd != 5'd31) begin rl[nr[1:0]] = rd; nr = nr + 3'd1; end
      end
      if (rn != 5'd31) begin rl[nr[1:0]] = rn; nr = nr + 3'd1; end
      if ((mode == M_PRE || mode == M_POST) && rn != 5'd31) begin
        wl[nw[0]] = rn; nw = nw + 2'd1;
      end
    end else if ((w & 32'h3F000000) == 32'h08000000) begin
      flags = (b30 ? F_64 : 6'd0) | F_SP; size = b30 ? 3'd4 : 3'd3; mode = M_OFF;
      if (w[22]) begin
        kind = K_LDXR;
        if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
      end else begin
        kind = K_STXR;
        if (rd != 5'd31) begin rl[nr[1:0]] = rd; nr = nr + 3'd1; end
      end
      if (rn != 5'd31) begin rl[nr[1:0]] = rn; nr = nr + 3'd1; end
    end else if ((w & 32'hFFFFF01F) == 32'hD503201F) begin
      kind = K_NOP;
    end else if ((w & 32'hFFFFF0FF) == 32'hD50330BF) begin
      kind = K_DMB;
    end else if ((w & 32'hFFFFF0FF) == 32'hD503309F) begin
      kind = K_DSB;
    end else if ((w & 32'hFFFFF0FF) == 32'hD50330DF) begin
      kind = K_ISB;
    end else if ((w & 32'hFFE0001F) == 32'hD4200000) begin
      kind = K_BRK; imm = 64'(i16);
    end else if ((w & 32'hFFE0001F) == 32'hD4000001) begin
      kind = K_SVC; imm = 64'(i16); flags = F_PRV;
    end else if ((w & 32'hFFF00000) == 32'hD5300000) begin
      kind = K_MRS; flags = F_PRV;
      if (rd != 5'd31) begin wl[0] = rd; nw = 2'd1; end
    end else if ((w & 32'hFFF00000) == 32'hD5100000) begin
      kind = K_MSR; flags = F_PRV;
      if (rd != 5'd31) begin rl[0] = rd; nr = 3'd1; end
    end else if ((w & 32'h3E000000) == 32'h2C000000) begin
      kind = K_SIMD;
      if (rn != 5'd31) begin rl[0] = rn; nr = 3'd1; end
    end else if (w[28:25] == 4'h7 || w[28:25] == 4'hF) begin
      kind = K_SIMD;
    end else if ((w & 32'hBF800000) == 32'h0D000000 ||
                 (w & 32'hBF800000) == 32'h0D800000) begin
      kind = K_SIMD;
      if (rn != 5'd31) begin rl[0] = rn; nr = 3'd1; end
    end else begin
      ok = 1'b0;
    end

    res.reg_fields = {ra, rm, rn, rd};
    if (ok) begin
      res.is_valid = 1'b1;
      res.op_kind = kind;
      res.immediate = imm;
      res.branch_offset = tgt;
      res.condition = cond;
      res.attr_flags = flags;
      res.shift_info = {sht, sha};
      res.test_bit = tbit;
      res.mem_access = {size, mode};
      res.reads_list = {nr, rl[3], rl[2], rl[1], rl[0]};
      res.writes_list = {nw, wl[1], wl[0]};
    end else begin
      res.is_valid = 1'b0;
      res.op_kind = K_NONE;
      res.immediate = '0;
      res.branch_offset = '0;
      res.condition = '0;
      res.attr_flags = '0;
      res.shift_info = '0;
      res.test_bit = '0;
      res.mem_access = '0;
      res.reads_list = '0;
      res.writes_list = '0;
    end
  end
endmodule

@@ rtl/aarch64_instruction_classifier_core.sv @@
// Accepted words are registered at the input; the decode result is registered at the output.
// Throughput: one word per cycle while the output is taken; the decode is one pass of logic between the registers.
// A two-entry pipe stalls only when both stages hold items and the output is not taken.
// Reset (rst_n low, synchronous) empties both stages; the word and result registers are not reset.
`timescale 1ns / 1ps
`include "aarch64_instruction_classifier_core_defines.svh"
module aarch64_instruction_classifier_core
  import aic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  aic_in_if.sink      in_ch,
  aic_out_if.source   out_ch
);
  logic        s1_vld_r, s1_vld_nxt;
  logic [31:0] s1_word_r;
  logic        s2_vld_r, s2_vld_nxt;
  dec_res_t    s2_res_r;
  dec_res_t    dec_res;
  logic        s2_load;
  logic        s1_adv;
  logic        in_fire;

  aic_decode u_dec (.w(s1_word_r), .res(dec_res));

  assign s2_load = !s2_vld_r || out_ch.ready;
  assign s1_adv = s1_vld_r && s2_load;
  assign in_ch.ready = !s1_vld_r || s2_load;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_ch.valid = s2_vld_r;
  assign out_ch.res = s2_res_r;

  always_comb begin
    s1_vld_nxt = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);
    s2_vld_nxt = s2_load ? s1_vld_r : s2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_word_r <= in_ch.instr_word;
    if (s1_adv) s2_res_r <= dec_res;
  end

  `AIC_ASSERT_NXT(a_s1_moves, s1_vld_r && s2_load, s2_vld_r, "decoded item not captured")
  `AIC_ASSERT_IMP(a_valid_kind, s2_vld_r, out_ch.res.is_valid == (out_ch.res.op_kind != K_NONE), "valid and kind disagree")
  `AIC_ASSERT_NXT(a_stall_hold, s2_vld_r && !out_ch.ready, s2_vld_r, "result dropped while stalled")
endmodule

@@ bench/aic_decode_checker.sv @@
// Checker: watches both channels, predicts each decode result and compares field by field.
`timescale 1ns / 1ps
module aic_decode_checker
  import aic_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  dec_res_t    out_res,
  output int          err_count,
  output int          pending
);

  typedef struct {
    op_kind_t    kind;
    logic [3:0]  cond;
    logic [5:0]  flags;
    logic [1:0]  sht;
    logic [5:0]  sha;
    logic [5:0]  tbit;
    mem_mode_t   mode;
    logic [2:0]  size;
    logic [63:0] imm;
    logic [63:0] tgt;
    logic [4:0]  rl[4];
    int          nr;
    logic [4:0]  wl[2];
    int          nw;
  } dec_t;

  dec_res_t expected_q[$];

  function automatic logic [63:0] sx(logic [63:0] v, int n);
    logic [63:0] m;
    m = 64'd1 << (n - 1);
    v = v & ((m << 1) - 64'd1);
    return (v ^ m) - m;
  endfunction

  function automatic void add_rd(ref dec_t d, input logic [4:0] r);
    if (r != 5'd31 && d.nr < 4) begin
      d.rl[d.nr] = r;
      d.nr++;
    end
  endfunction

  function automatic void add_wr(ref dec_t d, input logic [4:0] r);
    if (r != 5'd31 && d.nw < 2) begin
      d.wl[d.nw] = r;
      d.nw++;
    end
  endfunction

  function automatic logic [63:0] logic_mask(logic sf, logic n, logic [5:0] immr,
                                             logic [5:0] imms);
    logic [6:0] comb;
    int len, esize;
    logic [63:0] emask, el, m;
    logic [5:0] s, r;
    comb = {n, ~imms};
    len = 0;
    for (int i = 6; i >= 1; i--) begin
      if (comb[i] && len == 0) len = i;
    end
    if (len == 0) return 64'd0;
    esize = 1 << len;
    s = imms & 6'(esize - 1);
    r = immr & 6'(esize - 1);
    emask = (esize == 64) ? '1 : ((64'd1 << esize) - 64'd1);
    el = (s == 6'd63) ? '1 : ((64'd1 << (s + 1)) - 64'd1);
    if (r != 0) el = ((el >> r) | (el << (esize - r))) & emask;
    m = 0;
    for (int i = 0; i < 64; i += esize) m |= el << i;
    if (!sf) m &= 64'hFFFF_FFFF;
    return m;
  endfunction

  function automatic bit decode_word(logic [31:0] w, ref dec_t d);
    logic [4:0] rd, rn, rm, ra;
    logic sf, b30, b29, rg, ld;
    logic [1:0] opc, idx, sz;
    logic [5:0] sh;
    logic [63:0] v, i16;
    int scale;
    rd = w[4:0]; rn = w[9:5]; rm = w[20:16]; ra = w[14:10];
    sf = w[31]; b30 = w[30]; b29 = w[29];
    if ((w & 32'h7C000000) == 32'h14000000) begin
      v = sx(64'(w[25:0]), 26) << 2;
      d.kind = sf ? K_BL : K_B; d.tgt = v; d.imm = v; d.flags = F_CF;
      if (sf) add_wr(d, 5'd30);
      return 1;
    end
    if ((w & 32'hFF000010) == 32'h54000000) begin
      d.kind = K_BCOND; d.tgt = sx(64'(w[23:5]), 19) << 2;
      d.cond = w[3:0]; d.flags = F_RDF | F_CF;
      return 1;
    end
    if ((w & 32'h7E000000) == 32'h34000000) begin
      d.kind = w[24] ? K_CBNZ : K_CBZ; d.tgt = sx(64'(w[23:5]), 19) << 2;
      d.flags = F_CF | (sf ? F_64 : 6'd0); add_rd(d, rd);
      return 1;
    end
    if ((w & 32'h7E000000) == 32'h36000000) begin
      d.kind = w[24] ? K_TBNZ : K_TBZ; d.tgt = sx(64'(w[18:5]), 14) << 2;
      d.tbit = {sf, w[23:19]};
      d.flags = F_CF | (sf ? F_64 : 6'd0); add_rd(d, rd);
      return 1;
    end
    if ((w & 32'hFFFFFC1F) == 32'hD61F0000) begin
      d.kind = K_BR; d.flags = F_CF; add_rd(d, rn); return 1;
    end
    if ((w & 32'hFFFFFC1F) == 32'hD63F0000) begin
      d.kind = K_BLR; d.flags = F_CF; add_rd(d, rn); add_wr(d, 5'd30); return 1;
    end
    if ((w & 32'hFFFFFC1F) == 32'hD65F0000) begin
      d.kind = K_RET; d.flags = F_CF; add_rd(d, rn); return 1;
    end
    if ((w & 32'hFFFFFBFF) == 32'hD65F0BFF) begin d.kind = K_RETAA; d.flags = F_CF; return 1; end
    if ((w & 32'hFFFFFBFF) == 32'hD503233F) begin d.kind = K_PACIASP; d.flags = F_PRV; return 1; end
    if ((w & 32'hFFFFFBFF) == 32'hD50323BF) begin d.kind = K_AUTIASP; d.flags = F_PRV; return 1; end
    if ((w & 32'hFFFFFC00) == 32'hDAC10000) begin d.kind = K_PACIASP; d.flags = F_PRV; return 1; end
    if ((w & 32'hFFFFFC00) == 32'hDAC11000) begin d.kind = K_AUTIASP; d.flags = F_PRV; return 1; end
    if ((w & 32'h1F000000) == 32'h11000000 || (w & 32'h1F000000) == 32'h0B000000) begin
      rg = (w & 32'h1F000000) == 32'h0B000000;
      d.flags = (sf ? F_64 : 6'd0) | (b29 ? F_SET : 6'd0);
      if (rg) begin
        d.sht = w[23:22]; d.sha = w[15:10];
      end else begin
        d.imm = 64'(w[21:10]) << (w[22] ? 12 : 0);
        d.flags |= F_SP;
      end
      add_rd(d, rn);
      if (rg) add_rd(d, rm);
      if (b29 && rd == 5'd31) d.kind = b30 ? K_CMP : K_CMN;
      else begin
        d.kind = b29 ? (b30 ? K_SUBS : K_ADDS) : (b30 ? K_SUB : K_ADD);
        add_wr(d, rd);
      end
      return 1;
    end
    if ((w & 32'h1F000000) == 32'h0A000000) begin
      opc = w[30:29];
      d.sht = w[23:22]; d.sha = w[15:10]; d.flags = sf ? F_64 : 6'd0;
      if (opc == 1 && !w[21] && rn == 5'd31 && d.sht == 0 && d.sha == 0) begin
        d.kind = K_MOVREG; add_rd(d, rm); add_wr(d, rd); return 1;
      end
      if (opc == 1 && w[21] && rn == 5'd31) begin
        d.kind = K_MVN; add_rd(d, rm); add_wr(d, rd); return 1;
      end
      if (opc == 3 && rd == 5'd31) begin
        d.kind = K_TST; d.flags |= F_SET; add_rd(d, rn); add_rd(d, rm); return 1;
      end
      case (opc)
        2'd0: d.kind = w[21] ? K_BIC : K_AND;
        2'd1: d.kind = w[21] ? K_ORN : K_ORR;
        2'd2: d.kind = w[21] ? K_EON : K_EOR;
        default: begin
          d.kind = K_ANDS; d.flags |= F_SET;
        end
      endcase
      add_rd(d, rn); add_rd(d, rm); add_wr(d, rd);
      return 1;
    end
    if ((w & 32'h1F800000) == 32'h12000000) begin
      opc = w[30:29];
      d.imm = logic_mask(sf, w[22], w[21:16], w[15:10]);
      d.flags = sf ? F_64 : 6'd0;
      if (opc == 3 && rd == 5'd31) begin
        d.kind = K_TST; d.flags |= F_SET; add_rd(d, rn); return 1;
      end
      case (opc)
        2'd0: d.kind = K_AND;
        2'd1: d.kind = K_ORR;
        2'd2: d.kind = K_EOR;
        default: begin
          d.kind = K_ANDS; d.flags |= F_SET;
        end
      endcase
      add_rd(d, rn); add_wr(d, rd);
      return 1;
    end
    if ((w & 32'h1F800000) == 32'h12800000) begin
      opc = w[30:29]; sh = 6'(w[22:21]) * 6'd16; i16 = 64'(w[20:5]);
      d.flags = sf ? F_64 : 6'd0;
      add_wr(d, rd);
      if (opc == 3) begin
        d.kind = K_MOVK; d.imm = i16; d.sha = sh; add_rd(d, rd); return 1;
      end
      d.kind = K_MOVIMM;
      if (opc == 2) d.imm = i16 << sh;
      else d.imm = ~(i16 << sh) & (sf ? 64'hFFFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF);
      return 1;
    end
    if ((w & 32'h1F000000) == 32'h10000000) begin
      v = sx({43'd0, w[23:5], w[30:29]}, 21);
      d.kind = sf ? K_ADRP : K_ADR; d.imm = sf ? (v << 12) : v;
      d.flags = F_64 | F_CF; add_wr(d, rd);
      return 1;
    end
    if ((w & 32'h1FE00000) == 32'h1A800000) begin
      d.cond = w[15:12]; d.flags = (sf ? F_64 : 6'd0) | F_RDF;
      if (!b30 && w[11:10] == 0) d.kind = K_CSEL;
      else if (!b30 && w[11:10] == 1) d.kind = K_CSINC;
      else if (b30 && w[11:10] == 0) d.kind = K_CSINV;
      else d.kind = K_CSNEG;
      add_rd(d, rn); add_rd(d, rm); add_wr(d, rd);
      return 1;
    end
    if ((w & 32'h1FE00000) == 32'h1A400000) begin
      d.kind = b30 ? K_CCMP : K_CCMN; d.cond = w[15:12]; d.imm = 64'(w[3:0]);
      d.flags = (sf ? F_64 : 6'd0) | F_SET | F_RDF;
      add_rd(d, rn);
      if (!w[11]) add_rd(d, rm);
      return 1;
    end
    if ((w & 32'h1F000000) == 32'h1B000000) begin
      d.flags = sf ? F_64 : 6'd0;
      case (w[23:21])
        3'd0: d.kind = (ra == 5'd31) ? K_MUL : (w[15] ? K_MSUB : K_MADD);
        3'd1: d.kind = w[15] ? K_MSUB : K_SMULL;
        3'd5: d.kind = w[15] ? K_MSUB : K_UMULL;
        3'd2: d.kind = K_SMULH;
        3'd6: d.kind = K_UMULH;
        default: d.kind = K_MUL;
      endcase
      add_rd(d, rn); add_rd(d, rm);
      if (ra != 5'd31 && d.kind != K_MUL) add_rd(d, ra);
      add_wr(d, rd);
      return 1;
    end
    if ((w & 32'h1FE00000) == 32'h1AC00000) begin
      case (w[15:10])
        6'h02: d.kind = K_UDIV;
        6'h03: d.kind = K_SDIV;
        6'h08: d.kind = K_LSL;
        6'h09: d.kind = K_LSR;
        6'h0A: d.kind = K_ASR;
        6'h0B: d.kind = K_ROR;
        default: return 0;
      endcase
      d.flags = sf ? F_64 : 6'd0;
      add_rd(d, rn); add_rd(d, rm); add_wr(d, rd);
      return 1;
    end
    if ((w & 32'h1F800000) == 32'h13000000) begin
      opc = w[30:29];
      d.flags = sf ? F_64 : 6'd0; d.imm = 64'(w[21:16]); d.sha = w[15:10];
      d.kind = (opc == 0) ? K_SBFM : (opc == 2) ? K_UBFM : K_BFM;
      add_rd(d, rn); add_wr(d, rd);
      if (opc == 1) add_rd(d, rd);
      return 1;
    end
    if ((w & 32'h1F800000) == 32'h13800000) begin
      d.kind = (rn == rm) ? K_ROR : K_EXTR; d.flags = sf ? F_64 : 6'd0;
      d.imm = 64'(w[15:10]);
      add_rd(d, rn); add_rd(d, rm); add_wr(d, rd);
      return 1;
    end
    if ((w & 32'h3B000000) == 32'h39000000) begin
      sz = w[31:30]; opc = w[23:22];
      d.imm = 64'(w[21:10]) << sz;
      d.flags = ((sz == 3) ? F_64 : 6'd0) | F_SP;
      d.size = 3'(sz) + 3'd1; d.mode = M_OFF;
      if (opc == 0) begin
        d.kind = (sz == 0) ? K_STRB : (sz == 1) ? K_STRH : K_STR; add_rd(d, rd);
      end else if (opc == 1) begin
        d.kind = (sz == 0) ? K_LDRB : (sz == 1) ? K_LDRH : K_LDR; add_wr(d, rd);
      end else begin
        if (sz == 3) begin
          d.kind = K_NOP; return 1;
        end
        d.kind = (sz == 0) ? K_LDRSB : (sz == 1) ? K_LDRSH : K_LDRSW; add_wr(d, rd);
      end
      add_rd(d, rn);
      return 1;
    end
    if ((w & 32'h3E000000) == 32'h28000000) begin
      opc = w[31:30]; ld = w[22]; idx = w[24:23];
      scale = (opc == 0) ? 2 : 3;
      d.imm = sx(64'(w[21:15]), 7) << scale;
      d.flags = ((opc == 2) ? F_64 : 6'd0) | F_SP;
      d.size = 3'(scale + 1); d.kind = ld ? K_LDP : K_STP;
      d.mode = (idx == 1) ? M_POST : (idx == 2) ? M_OFF : M_PRE;
      if (ld) begin
        add_wr(d, rd); add_wr(d, ra);
      end else begin
        add_rd(d, rd); add_rd(d, ra);
      end
      add_rd(d, rn);
      if (d.mode != M_OFF) add_wr(d, rn);
      return 1;
    end
    if ((w & 32'h3B000000) == 32'h18000000) begin
      d.kind = K_LDR; d.tgt = sx(64'(w[23:5]), 19) << 2; d.imm = d.tgt;
      d.flags = b30 ? F_64 : 6'd0; d.size = b30 ? 3'd4 : 3'd3; d.mode = M_LIT;
      add_wr(d, rd);
      return 1;
    end
    if ((w & 32'h3B000000) == 32'h38000000) begin
      sz = w[31:30]; opc = w[23:22]; idx = w[11:10];
      d.flags = ((sz == 3) ? F_64 : 6'd0) | F_SP; d.size = 3'(sz) + 3'd1;
      if (w[21]) begin
        d.mode = M_REG; add_rd(d, rm);
      end else begin
        d.imm = sx(64'(w[20:12]), 9);
        d.mode = (idx == 0) ? M_OFF : (idx == 1) ? M_POST : M_PRE;
      end
      if (opc[0]) begin
        d.kind = K_LDR; add_wr(d, rd);
      end else begin
        d.kind = K_STR; add_rd(d, rd);
      end
      add_rd(d, rn);
      if (d.mode == M_PRE || d.mode == M_POST) add_wr(d, rn);
      return 1;
    end
    if ((w & 32'h3F000000) == 32'h08000000) begin
      d.flags = (b30 ? F_64 : 6'd0) | F_SP; d.size = b30 ? 3'd4 : 3'd3; d.mode = M_OFF;
      if (w[22]) begin
        d.kind = K_LDXR; add_wr(d, rd);
      end else begin
        d.kind = K_STXR; add_rd(d, rd);
      end
      add_rd(d, rn);
      return 1;
    end
    if ((w & 32'hFFFFF01F) == 32'hD503201F) begin d.kind = K_NOP; return 1; end
    if ((w & 32'hFFFFF0FF) == 32'hD50330BF) begin d.kind = K_DMB; return 1; end
    if ((w & 32'hFFFFF0FF) == 32'hD503309F) begin d.kind = K_DSB; return 1; end
    if ((w & 32'hFFFFF0FF) == 32'hD50330DF) begin d.kind = K_ISB; return 1; end
    if ((w & 32'hFFE0001F) == 32'hD4200000) begin
      d.kind = K_BRK; d.imm = 64'(w[20:5]); return 1;
    end
    if ((w & 32'hFFE0001F) == 32'hD4000001) begin
      d.kind = K_SVC; d.imm = 64'(w[20:5]); d.flags = F_PRV; return 1;
    end
    if ((w & 32'hFFF00000) == 32'hD5300000) begin
      d.kind = K_MRS; d.flags = F_PRV; add_wr(d, rd); return 1;
    end
    if ((w & 32'hFFF00000) == 32'hD5100000) begin
      d.kind = K_MSR; d.flags = F_PRV; add_rd(d, rd); return 1;
    end
    if ((w & 32'h3E000000) == 32'h2C000000) begin
      d.kind = K_SIMD; add_rd(d, rn); return 1;
    end
    if (w[28:25] == 4'h7 || w[28:25] == 4'hF) begin d.kind = K_SIMD; return 1; end
    if ((w & 32'hBF800000) == 32'h0D000000 || (w & 32'hBF800000) == 32'h0D800000) begin
      d.kind = K_SIMD; add_rd(d, rn); return 1;
    end
    return 0;
  endfunction

  function automatic void clear_dec(ref dec_t d);
    d.kind = K_NONE; d.cond = 0; d.flags = 0; d.sht = 0; d.sha = 0; d.tbit = 0;
    d.mode = M_NONE; d.size = 0; d.imm = 0; d.tgt = 0; d.nr = 0; d.nw = 0;
    for (int i = 0; i < 4; i++) d.rl[i] = 0;
    for (int i = 0; i < 2; i++) d.wl[i] = 0;
  endfunction

  function automatic dec_res_t predict_decode(logic [31:0] w);
    dec_t d;
    dec_res_t r;
    clear_dec(d);
    if (!decode_word(w, d)) clear_dec(d);
    r = '0;
    r.is_valid = d.kind != K_NONE;
    r.op_kind = d.kind;
    r.immediate = d.imm;
    r.branch_offset = d.tgt[27:0];
    r.condition = d.cond;
    r.reg_fields = {w[14:10], w[20:16], w[9:5], w[4:0]};
    r.attr_flags = d.flags;
    r.shift_info = {d.sht, d.sha};
    r.test_bit = d.tbit;
    r.mem_access = {d.size, d.mode};
    r.reads_list[22:20] = 3'(d.nr);
    for (int i = 0; i < d.nr; i++) r.reads_list[5*i +: 5] = d.rl[i];
    r.writes_list[11:10] = 2'(d.nw);
    for (int i = 0; i < d.nw; i++) r.writes_list[5*i +: 5] = d.wl[i];
    return r;
  endfunction

  task automatic cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  initial err_count = 0;
  assign pending = expected_q.size();

  always @(posedge clk) begin
    dec_res_t e;
    if (rst_n) begin
      if (in_valid && in_ready) expected_q.push_back(predict_decode(in_word));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("decode result with no word pending");
          err_count++;
        end else begin
          e = expected_q.pop_front();
          cmp_field("is_valid", e.is_valid, out_res.is_valid);
          cmp_field("op_kind", e.op_kind, out_res.op_kind);
          cmp_field("immediate", e.immediate, out_res.immediate);
          cmp_field("branch_offset", e.branch_offset, out_res.branch_offset);
          cmp_field("condition", e.condition, out_res.condition);
          cmp_field("reg_fields", e.reg_fields, out_res.reg_fields);
          cmp_field("attr_flags", e.attr_flags, out_res.attr_flags);
          cmp_field("shift_info", e.shift_info, out_res.shift_info);
          cmp_field("test_bit", e.test_bit, out_res.test_bit);
          cmp_field("mem_access", e.mem_access, out_res.mem_access);
          cmp_field("reads_list", e.reads_list, out_res.reads_list);
          cmp_field("writes_list", e.writes_list, out_res.writes_list);
        end
      end
    end
  end

endmodule

@@ bench/tb.sv @@
// Testbench top: drives instruction words, stalls the result side, gives the verdict.
`timescale 1ns / 1ps
module tb;
  import aic_pkg::*;

  localparam int NumRandom = 1250;
  localparam int IdleLimit = 5000;

  logic clk;
  logic rst_n;
  int   err_count;
  int   pending;
  int   idle_cycles;
  bit   quiet;
  bit   hold_off;

  aic_in_if  in_ch ();
  aic_out_if out_ch ();

  aarch64_instruction_classifier_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  aic_decode_checker chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_word  (in_ch.instr_word),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_res  (out_ch.res),
    .err_count(err_count),
    .pending  (pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  logic [31:0] directed[$] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h17FF_FFFF, 32'h9400_0000, 32'h5400_000B,
    32'hB4FF_FFE0, 32'h3700_0021, 32'hB7F8_0003, 32'hD61F_03E0, 32'hD63F_0020,
    32'hD65F_03C0, 32'hD65F_0FFF, 32'hD503_233F, 32'hD503_23BF, 32'hF100_043F,
    32'h8B02_0020, 32'hAA02_03E0, 32'hAA22_03E0, 32'hEA02_001F, 32'h9240_0000,
    32'h9200_F3E0, 32'h1200_7C00, 32'hF2A0_0020, 32'h9280_0000, 32'h9AC0_0C20
  };
  logic [31:0] templates[$] = '{
    32'h1400_0000, 32'h5400_0000, 32'h3400_0000, 32'h3600_0000, 32'hD61F_0000,
    32'h1100_0000, 32'h0B00_0000, 32'h0A00_0000, 32'h1200_0000, 32'h1280_0000,
    32'h1000_0000, 32'h1A80_0000, 32'h1A40_0000, 32'h1B00_0000, 32'h1AC0_0000,
    32'h1300_0000, 32'h1380_0000, 32'h3900_0000, 32'h2800_0000, 32'h1800_0000,
    32'h3800_0000, 32'h0800_0000, 32'hD503_201F, 32'hD420_0000, 32'hD530_0000,
    32'h2C00_0000, 32'h0D00_0000, 32'hDAC1_0000
  };
  logic [31:0] masks[$] = '{
    32'h83FF_FFFF, 32'h00FF_FFEF, 32'h81FF_FFFF, 32'h81FF_FFFF, 32'h0000_03E0,
    32'hE0FF_FFFF, 32'hE0FF_FFFF, 32'hE0FF_FFFF, 32'hE07F_FFFF, 32'hE07F_FFFF,
    32'hE0FF_FFFF, 32'hC01F_FFFF, 32'hC01F_FFFF, 32'hE0FF_FFFF, 32'h801F_FFFF,
    32'hE07F_FFFF, 32'hE07F_FFFF, 32'hC4FF_FFFF, 32'hC5FF_FFFF, 32'hC4FF_FFFF,
    32'hC4FF_FFFF, 32'h40FF_FFFF, 32'h0000_0FE0, 32'h001F_FFE0, 32'h000F_FFFF,
    32'hC1FF_FFFF, 32'h407F_FFFF, 32'h0000_13FF
  };

  function automatic logic [31:0] pick_word();
    int t;
    logic [31:0] w;
    if ($urandom_range(99) < 15) return $urandom();
    t = $urandom_range(templates.size() - 1);
    w = templates[t] | ($urandom() & masks[t]);
    // lean toward SP/XZR to hit list edge cases
    if ($urandom_range(3) == 0) w[4:0] = 5'd31;
    if ($urandom_range(3) == 0) w[9:5] = 5'd31;
    return w;
  endfunction

  task automatic send_word(logic [31:0] w, bit may_idle);
    while (may_idle && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.instr_word <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // result side: random stalls, a calm stretch, and one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    quiet = 0;
    hold_off = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 11);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge clk iff idle_cycles >= IdleLimit);
    $display("** aarch64_instruction_classifier_core: FAILED **");
    $finish;
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.instr_word = '0;
    rst_n            = 1'b0;
    idle_cycles      = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_word(directed[i], 1);
    in_ch.valid <= 1'b0;
    @(posedge clk iff pending == 0);
    for (int i = 0; i < NumRandom; i++) begin
      if (i == 300) quiet = 1;
      if (i == 500) quiet = 0;
      if (i == 700) hold_off = 1;
      if (i == 900) begin
        in_ch.valid <= 1'b0;
        @(posedge clk iff pending == 0);
      end
      send_word(pick_word(), !quiet);
    end
    in_ch.valid <= 1'b0;
    @(posedge clk iff pending == 0);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("** aarch64_instruction_classifier_core: PASSED **");
    end else begin
      $display("** aarch64_instruction_classifier_core: FAILED **");
    end
    $finish;
  end

endmodule
